/* sv/srtf_pkg.sv */
// ----------------------------------------------------------------------------
// srtf_pkg
// Shared types and constants of the shortest-remaining-time-first scheduler.
// ----------------------------------------------------------------------------
package srtf_pkg;

	localparam int SLOTS_DEF     = 16;
	localparam int TIME_BITS_DEF = 24;

	localparam int ID_W       = 8;
	localparam int BURST_W    = 16;
	localparam int OUT_TIME_W = 24;

	// command codes carried in tuser of the input side
	localparam logic CMD_ARRIVE = 1'b0;
	localparam logic CMD_TICK   = 1'b1;

	typedef enum logic [1:0] {
		STAT_ACCEPT = 2'd0,
		STAT_FULL   = 2'd1,
		STAT_RAN    = 2'd2,
		STAT_IDLE   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ARRIVE,
		S_SCAN,
		S_LAST,
		S_EXEC,
		S_METRIC,
		S_WAIT,
		S_DONE
	} state_t;

endpackage

/* sv/srtf_slot_mem.sv */
// ----------------------------------------------------------------------------
// srtf_slot_mem
// Process table: one record per slot, one write and one registered read
// per cycle.
// ----------------------------------------------------------------------------
module srtf_slot_mem #(
	parameter int SLOTS     = srtf_pkg::SLOTS_DEF,
	parameter int TIME_BITS = srtf_pkg::TIME_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [$clog2(SLOTS)-1:0]      waddr,
	input  logic [srtf_pkg::ID_W-1:0]     w_id,
	input  logic [srtf_pkg::BURST_W-1:0]  w_rem,
	input  logic [srtf_pkg::BURST_W-1:0]  w_burst,
	input  logic [TIME_BITS-1:0]          w_arr,
	input  logic                          w_started,
	input  logic [TIME_BITS-1:0]          w_resp,
	input  logic [$clog2(SLOTS)-1:0]      raddr,
	output logic [srtf_pkg::ID_W-1:0]     r_id,
	output logic [srtf_pkg::BURST_W-1:0]  r_rem,
	output logic [srtf_pkg::BURST_W-1:0]  r_burst,
	output logic [TIME_BITS-1:0]          r_arr,
	output logic                          r_started,
	output logic [TIME_BITS-1:0]          r_resp
);

	localparam int REC_W = srtf_pkg::ID_W + 2 * srtf_pkg::BURST_W + 1 + 2 * TIME_BITS;

	logic [REC_W-1:0] mem [SLOTS];
	logic [REC_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= {w_id, w_rem, w_burst, w_arr, w_started, w_resp};
		end
		rd_q <= mem[raddr];
	end

	assign {r_id, r_rem, r_burst, r_arr, r_started, r_resp} = rd_q;

endmodule

/* sv/srtf_process_scheduler.sv */
// ----------------------------------------------------------------------------
// srtf_process_scheduler
// Preemptive shortest-remaining-time-first scheduler over a table of slots.
// ----------------------------------------------------------------------------
// One item is taken at a time; s_axis_tready is high only while the block
// waits for work. A tick item scans the slot table one slot per cycle
// through the single read port of the table memory; when the chosen
// process completes, the states S_METRIC and S_WAIT then form its
// turnaround and waiting time. An arrive item walks the valid bits from
// slot 0 and stops at the first free slot. A result waits in the output
// register while the next item is already being worked on. Time saturates
// at 2^TIME_BITS - 1 and all time fields are reported in their low 24 bits.
module srtf_process_scheduler #(
	parameter int SLOTS     = srtf_pkg::SLOTS_DEF,
	parameter int TIME_BITS = srtf_pkg::TIME_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [23:0]  s_axis_tdata,   // proc_id[7:0], burst_len[23:8]
	input  logic [0:0]   s_axis_tuser,   // command[0]
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// run_id[7:0], finished[8], turnaround[32:9], waiting[56:33],
	// response[80:57], time_now[104:81], zero fill[111:105]
	output logic [111:0] m_axis_tdata,
	output logic [1:0]   m_axis_tuser    // status[1:0]
);

	localparam int IDX_W = $clog2(SLOTS);
	localparam int OW    = srtf_pkg::OUT_TIME_W;
	localparam int EXT_W = (TIME_BITS > OW) ? TIME_BITS : OW;
	localparam logic [IDX_W-1:0]     LAST_IDX = IDX_W'(SLOTS - 1);
	localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

	srtf_pkg::state_t  state_q, nxt;
	srtf_pkg::status_t status_q;

	logic [IDX_W-1:0]               idx_q;
	logic                           valid_q [SLOTS];
	logic [TIME_BITS-1:0]           clock_q;
	logic [srtf_pkg::ID_W-1:0]      id_q;
	logic [srtf_pkg::BURST_W-1:0]   burst_q;

	logic                           cand_on_s1;
	logic                           cand_vld_s1;
	logic [IDX_W-1:0]               cand_idx_s1;

	logic                           best_found_q;
	logic [IDX_W-1:0]               best_idx_q;
	logic [srtf_pkg::ID_W-1:0]      best_id_q;
	logic [srtf_pkg::BURST_W-1:0]   best_rem_q;
	logic [srtf_pkg::BURST_W-1:0]   best_burst_q;
	logic [TIME_BITS-1:0]           best_arr_q;
	logic                           best_started_q;
	logic [TIME_BITS-1:0]           best_resp_q;

	logic                           fin_q;
	logic [TIME_BITS-1:0]           turn_q;
	logic [EXT_W-1:0]               wait_q;

	logic                           out_valid_q;
	logic [111:0]                   out_data_q;
	logic [1:0]                     out_user_q;

	// table ports
	logic                           mem_we;
	logic [IDX_W-1:0]               mem_wa;
	logic [srtf_pkg::ID_W-1:0]      mem_w_id;
	logic [srtf_pkg::BURST_W-1:0]   mem_w_rem;
	logic [srtf_pkg::BURST_W-1:0]   mem_w_burst;
	logic [TIME_BITS-1:0]           mem_w_arr;
	logic                           mem_w_started;
	logic [TIME_BITS-1:0]           mem_w_resp;
	logic [srtf_pkg::ID_W-1:0]      rd_id;
	logic [srtf_pkg::BURST_W-1:0]   rd_rem;
	logic [srtf_pkg::BURST_W-1:0]   rd_burst;
	logic [TIME_BITS-1:0]           rd_arr;
	logic                           rd_started;
	logic [TIME_BITS-1:0]           rd_resp;

	logic                           in_acc;
	logic                           out_load;
	logic [srtf_pkg::BURST_W-1:0]   in_burst;
	logic [srtf_pkg::BURST_W-1:0]   burst_fix;
	logic [TIME_BITS-1:0]           clock_inc;
	logic [TIME_BITS-1:0]           resp_new;
	logic [srtf_pkg::BURST_W-1:0]   rem_dec;
	logic                           last_unit;
	logic                           better;
	logic                           take;
	logic [EXT_W-1:0]               turn_x;
	logic [EXT_W-1:0]               burst_x;
	logic [EXT_W-1:0]               resp_x;
	logic [EXT_W-1:0]               clock_x;
	logic [srtf_pkg::ID_W-1:0]      run_id_o;
	logic [OW-1:0]                  turn_o;
	logic [OW-1:0]                  wait_o;
	logic [OW-1:0]                  resp_o;

	srtf_slot_mem #(
		.SLOTS     (SLOTS),
		.TIME_BITS (TIME_BITS)
	) u_slot_mem (
		.clk       (clk),
		.we        (mem_we),
		.waddr     (mem_wa),
		.w_id      (mem_w_id),
		.w_rem     (mem_w_rem),
		.w_burst   (mem_w_burst),
		.w_arr     (mem_w_arr),
		.w_started (mem_w_started),
		.w_resp    (mem_w_resp),
		.raddr     (idx_q),
		.r_id      (rd_id),
		.r_rem     (rd_rem),
		.r_burst   (rd_burst),
		.r_arr     (rd_arr),
		.r_started (rd_started),
		.r_resp    (rd_resp)
	);

	assign in_acc    = s_axis_tvalid && s_axis_tready;
	assign out_load  = (state_q == srtf_pkg::S_DONE) && (!out_valid_q || m_axis_tready);
	assign in_burst  = s_axis_tdata[23:8];
	assign burst_fix = (in_burst == '0) ? srtf_pkg::BURST_W'(1) : in_burst;
	assign clock_inc = (clock_q == TIME_MAX) ? clock_q : clock_q + 1'b1;
	assign resp_new  = best_started_q ? best_resp_q : clock_q - best_arr_q;
	assign rem_dec   = best_rem_q - 1'b1;
	assign last_unit = (best_rem_q == srtf_pkg::BURST_W'(1));

	// least remaining time wins; equal time goes to the earlier arrival,
	// equal arrival keeps the lower slot seen first
	assign better = (rd_rem < best_rem_q) ||
			((rd_rem == best_rem_q) && (rd_arr < best_arr_q));
	assign take   = cand_on_s1 && cand_vld_s1 && (!best_found_q || better);

	assign turn_x  = EXT_W'(turn_q);
	assign burst_x = EXT_W'(best_burst_q);
	assign resp_x  = EXT_W'(best_resp_q);
	assign clock_x = EXT_W'(clock_q);

	assign run_id_o = (status_q == srtf_pkg::STAT_RAN) ? best_id_q : '0;
	assign turn_o   = fin_q ? turn_x[OW-1:0] : '0;
	assign wait_o   = fin_q ? wait_q[OW-1:0] : '0;
	assign resp_o   = fin_q ? resp_x[OW-1:0] : '0;

	always_comb begin
		nxt           = state_q;
		s_axis_tready = (state_q == srtf_pkg::S_IDLE);
		mem_we        = 1'b0;
		mem_wa        = idx_q;
		mem_w_id      = id_q;
		mem_w_rem     = burst_q;
		mem_w_burst   = burst_q;
		mem_w_arr     = clock_q;
		mem_w_started = 1'b0;
		mem_w_resp    = '0;
		case (state_q)
			srtf_pkg::S_IDLE: begin
				if (s_axis_tvalid) begin
					nxt = (s_axis_tuser[0] == srtf_pkg::CMD_ARRIVE) ?
						srtf_pkg::S_ARRIVE : srtf_pkg::S_SCAN;
				end
			end
			srtf_pkg::S_ARRIVE: begin
				if (!valid_q[idx_q]) begin
					mem_we = 1'b1;
					nxt    = srtf_pkg::S_DONE;
				end else if (idx_q == LAST_IDX) begin
					nxt = srtf_pkg::S_DONE;
				end
			end
			srtf_pkg::S_SCAN: begin
				if (idx_q == LAST_IDX) begin
					nxt = srtf_pkg::S_LAST;
				end
			end
			srtf_pkg::S_LAST: begin
				nxt = srtf_pkg::S_EXEC;
			end
			srtf_pkg::S_EXEC: begin
				if (best_found_q && last_unit) begin
					nxt = srtf_pkg::S_METRIC;
				end else begin
					// write back the run slot with one unit less
					mem_we        = best_found_q;
					mem_wa        = best_idx_q;
					mem_w_id      = best_id_q;
					mem_w_rem     = rem_dec;
					mem_w_burst   = best_burst_q;
					mem_w_arr     = best_arr_q;
					mem_w_started = 1'b1;
					mem_w_resp    = resp_new;
					nxt           = srtf_pkg::S_DONE;
				end
			end
			srtf_pkg::S_METRIC: begin
				nxt = srtf_pkg::S_WAIT;
			end
			srtf_pkg::S_WAIT: begin
				nxt = srtf_pkg::S_DONE;
			end
			srtf_pkg::S_DONE: begin
				if (!out_valid_q || m_axis_tready) begin
					nxt = srtf_pkg::S_IDLE;
				end
			end
			default: begin
				nxt = srtf_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= srtf_pkg::S_IDLE;
			idx_q        <= '0;
			clock_q      <= '0;
			cand_on_s1   <= 1'b0;
			best_found_q <= 1'b0;
			out_valid_q  <= 1'b0;
			for (int i = 0; i < SLOTS; i++) begin
				valid_q[i] <= 1'b0;
			end
		end else begin
			state_q    <= nxt;
			cand_on_s1 <= (state_q == srtf_pkg::S_SCAN);
			if (take) begin
				best_found_q <= 1'b1;
			end
			case (state_q)
				srtf_pkg::S_IDLE: begin
					if (in_acc) begin
						idx_q        <= '0;
						best_found_q <= 1'b0;
					end
				end
				srtf_pkg::S_ARRIVE: begin
					if (!valid_q[idx_q]) begin
						valid_q[idx_q] <= 1'b1;
					end else if (idx_q != LAST_IDX) begin
						idx_q <= idx_q + 1'b1;
					end
				end
				srtf_pkg::S_SCAN: begin
					if (idx_q != LAST_IDX) begin
						idx_q <= idx_q + 1'b1;
					end
				end
				srtf_pkg::S_EXEC: begin
					clock_q <= clock_inc;
					if (best_found_q && last_unit) begin
						valid_q[best_idx_q] <= 1'b0;
					end
				end
				default: begin
				end
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cand_idx_s1 <= idx_q;
		cand_vld_s1 <= valid_q[idx_q];
		if (take) begin
			best_idx_q     <= cand_idx_s1;
			best_id_q      <= rd_id;
			best_rem_q     <= rd_rem;
			best_burst_q   <= rd_burst;
			best_arr_q     <= rd_arr;
			best_started_q <= rd_started;
			best_resp_q    <= rd_resp;
		end
		case (state_q)
			srtf_pkg::S_IDLE: begin
				if (in_acc) begin
					id_q    <= s_axis_tdata[7:0];
					burst_q <= burst_fix;
					fin_q   <= 1'b0;
				end
			end
			srtf_pkg::S_ARRIVE: begin
				if (!valid_q[idx_q]) begin
					status_q <= srtf_pkg::STAT_ACCEPT;
				end else begin
					status_q <= srtf_pkg::STAT_FULL;
				end
			end
			srtf_pkg::S_EXEC: begin
				status_q <= best_found_q ? srtf_pkg::STAT_RAN : srtf_pkg::STAT_IDLE;
				if (best_found_q) begin
					best_rem_q  <= rem_dec;
					best_resp_q <= resp_new;
					fin_q       <= last_unit;
				end
			end
			srtf_pkg::S_METRIC: begin
				// clock_q already holds the completion time here
				turn_q <= clock_q - best_arr_q;
			end
			srtf_pkg::S_WAIT: begin
				wait_q <= (turn_x >= burst_x) ? turn_x - burst_x : '0;
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_user_q <= status_q;
			out_data_q <= {7'b0, clock_x[OW-1:0], resp_o, wait_o, turn_o, fin_q, run_id_o};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

	a_fin_ran : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q[8] |-> out_user_q == srtf_pkg::STAT_RAN)
		else $error("finished item without a run status");

	a_clock_mono : assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> clock_q >= $past(clock_q))
		else $error("time went backwards");

	a_exec_valid : assert property (@(posedge clk) disable iff (!arst_n)
		state_q == srtf_pkg::S_EXEC && best_found_q |-> valid_q[best_idx_q])
		else $error("picked slot is not in use");

	a_wait_le_turn : assert property (@(posedge clk) disable iff (!arst_n)
		state_q == srtf_pkg::S_DONE && fin_q |-> wait_q <= turn_x)
		else $error("waiting time exceeds turnaround");

endmodule

/* test/srtf_process_scheduler_tb.sv */
// ----------------------------------------------------------------------------
// srtf_process_scheduler_tb
// Self-checking bench for the shortest-remaining-time-first scheduler: a
// short table of directed items, then random arrive/tick traffic with
// random idling on both streams. Every result is checked field by field
// against typed rows or the in-bench scheduling model, oldest first.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module srtf_process_scheduler_tb;

	localparam int SLOTS       = srtf_pkg::SLOTS_DEF;
	localparam int DIR_ROWS    = 24;
	localparam int RAND_ITEMS  = 1330;
	localparam int QUIET_ITEMS = 150;
	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_PRINTS  = 40;

	typedef struct {
		srtf_pkg::status_t status;
		logic [7:0]        run_id;
		logic              finished;
		logic [23:0]       turnaround;
		logic [23:0]       waiting;
		logic [23:0]       response;
		logic [23:0]       time_now;
	} sched_result_t;

	// one directed row: stimulus, then the typed expectation when typed is set
	typedef struct packed {
		logic        cmd;
		logic [7:0]  id;
		logic [15:0] burst;
		logic        typed;
		logic [1:0]  status;
		logic [7:0]  run_id;
		logic        finished;
		logic [23:0] turnaround;
		logic [23:0] waiting;
		logic [23:0] response;
		logic [23:0] time_now;
	} dir_row_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_valid = 1'b0;
	logic [23:0]  s_data = '0;
	logic [0:0]   s_user = srtf_pkg::CMD_TICK;
	logic         m_ready = 1'b0;
	logic         s_axis_tready;
	logic         m_axis_tvalid;
	logic [111:0] m_axis_tdata;
	logic [1:0]   m_axis_tuser;

	srtf_process_scheduler u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_valid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_data),
		.s_axis_tuser (s_user),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_ready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// scheduling model state
	logic        sch_valid   [SLOTS];
	logic [7:0]  sch_id      [SLOTS];
	logic [15:0] sch_left    [SLOTS];
	logic [15:0] sch_burst   [SLOTS];
	logic [23:0] sch_arrival [SLOTS];
	logic        sch_started [SLOTS];
	logic [23:0] sch_resp    [SLOTS];
	logic [23:0] sch_time;

	sched_result_t pending_results[$];
	int            errors = 0;
	int            results_seen = 0;
	int            items_sent = 0;
	int            status_count[4] = '{0, 0, 0, 0};
	int            completions = 0;
	int            cycle_count = 0;
	int            gap_pct = 0;
	int            stall_pct = 0;
	int            stall_left = 0;
	bit            idle_off = 1'b0;

	// one scheduler step: arrive into the lowest free slot, or run the best slot
	function automatic sched_result_t schedule_step(logic cmd, logic [7:0] id,
			logic [15:0] burst);
		sched_result_t r;
		int            pick;
		logic [23:0]   ta;
		r.status     = srtf_pkg::STAT_ACCEPT;
		r.run_id     = '0;
		r.finished   = 1'b0;
		r.turnaround = '0;
		r.waiting    = '0;
		r.response   = '0;
		pick         = -1;
		if (cmd == srtf_pkg::CMD_ARRIVE) begin
			for (int s = SLOTS - 1; s >= 0; s--)
				if (!sch_valid[s])
					pick = s;
			if (pick < 0) begin
				r.status = srtf_pkg::STAT_FULL;
			end else begin
				sch_valid[pick]   = 1'b1;
				sch_id[pick]      = id;
				sch_burst[pick]   = (burst == 16'd0) ? 16'd1 : burst;
				sch_left[pick]    = sch_burst[pick];
				sch_arrival[pick] = sch_time;
				sch_started[pick] = 1'b0;
				sch_resp[pick]    = '0;
			end
		end else begin
			for (int s = 0; s < SLOTS; s++) begin
				if (sch_valid[s] && (pick < 0 || sch_left[s] < sch_left[pick] ||
						(sch_left[s] == sch_left[pick] &&
						sch_arrival[s] < sch_arrival[pick])))
					pick = s;
			end
			if (pick < 0) begin
				r.status = srtf_pkg::STAT_IDLE;
			end else begin
				r.status = srtf_pkg::STAT_RAN;
				r.run_id = sch_id[pick];
				if (!sch_started[pick]) begin
					sch_started[pick] = 1'b1;
					sch_resp[pick]    = sch_time - sch_arrival[pick];
				end
				sch_left[pick] = sch_left[pick] - 16'd1;
			end
			if (sch_time != '1)
				sch_time = sch_time + 24'd1;
			if (pick >= 0 && sch_left[pick] == 16'd0) begin
				ta           = sch_time - sch_arrival[pick];
				r.finished   = 1'b1;
				r.turnaround = ta;
				r.waiting    = (ta >= 24'(sch_burst[pick])) ? ta - 24'(sch_burst[pick]) : '0;
				r.response   = sch_resp[pick];
				sch_valid[pick] = 1'b0;
			end
		end
		r.time_now = sch_time;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [23:0] got, logic [23:0] want);
		errors++;
		if (errors <= MAX_PRINTS)
			$display("mismatch on result %0d, %s: got 0x%0h, want 0x%0h",
				results_seen, what, got, want);
	endtask

	// present one item and hold it until the scheduler takes it
	task automatic offer_item(logic cmd, logic [7:0] id, logic [15:0] burst);
		if (!idle_off && $urandom_range(0, 99) < gap_pct) begin
			s_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		s_valid <= 1'b1;
		s_user  <= cmd;
		s_data  <= {burst, id};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic note_expected(sched_result_t r);
		pending_results.push_back(r);
		status_count[r.status]++;
		if (r.finished)
			completions++;
	endtask

	// result side: check accepted results and stall in random bursts
	always @(posedge clk) begin
		sched_result_t want;
		if (arst_n && m_axis_tvalid && m_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with nothing pending", 24'(m_axis_tuser), '0);
			end else begin
				want = pending_results.pop_front();
				if (m_axis_tuser != want.status)
					report_mismatch("status", 24'(m_axis_tuser), 24'(want.status));
				if (m_axis_tdata[7:0] != want.run_id)
					report_mismatch("run_id", 24'(m_axis_tdata[7:0]), 24'(want.run_id));
				if (m_axis_tdata[8] != want.finished)
					report_mismatch("finished", 24'(m_axis_tdata[8]), 24'(want.finished));
				if (m_axis_tdata[32:9] != want.turnaround)
					report_mismatch("turnaround", m_axis_tdata[32:9], want.turnaround);
				if (m_axis_tdata[56:33] != want.waiting)
					report_mismatch("waiting", m_axis_tdata[56:33], want.waiting);
				if (m_axis_tdata[80:57] != want.response)
					report_mismatch("response", m_axis_tdata[80:57], want.response);
				if (m_axis_tdata[104:81] != want.time_now)
					report_mismatch("time_now", m_axis_tdata[104:81], want.time_now);
			end
			results_seen++;
		end
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_ready    <= 1'b0;
		end else if (!idle_off && $urandom_range(0, 99) < stall_pct) begin
			stall_left <= $urandom_range(0, 8);
			m_ready    <= 1'b0;
		end else begin
			m_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending",
				cycle_count, pending_results.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	dir_row_t      dir_rows [DIR_ROWS];
	sched_result_t predicted;
	sched_result_t typed_want;
	logic          rnd_cmd;
	logic [7:0]    rnd_id;
	logic [15:0]   rnd_burst;
	int            arrive_pct;
	int            long_jobs;

	initial begin
		dir_rows = '{
			// idle tick right after reset, then a zero burst that runs as one unit
			'{srtf_pkg::CMD_TICK, 8'h00, 16'h0000, 1'b1, srtf_pkg::STAT_IDLE,
				8'h00, 1'b0, 24'd0, 24'd0, 24'd0, 24'd1},
			'{srtf_pkg::CMD_ARRIVE, 8'h00, 16'h0000, 1'b1, srtf_pkg::STAT_ACCEPT,
				8'h00, 1'b0, 24'd0, 24'd0, 24'd0, 24'd1},
			'{srtf_pkg::CMD_TICK, 8'h00, 16'h0000, 1'b1, srtf_pkg::STAT_RAN,
				8'h00, 1'b1, 24'd1, 24'd0, 24'd0, 24'd2},
			'{srtf_pkg::CMD_ARRIVE, 8'hFF, 16'hFFFF, 1'b1, srtf_pkg::STAT_ACCEPT,
				8'h00, 1'b0, 24'd0, 24'd0, 24'd0, 24'd2},
			// fill the rest of the table, equal bursts at equal time tie on slot
			'{srtf_pkg::CMD_ARRIVE, 8'hAA, 16'd2,  1'b0, '0, '0, '0, '0, '0, '0, '0},
			'{srtf_pkg::CMD_ARRIVE, 8'h55, 16'd2,  1'b0, '0, '0, '0, '0, '0, '0, '0},
			'{srtf_pkg::CMD_ARRIVE, 8'h10, 16'd1,  1'b0, '0, '0, '0, '0, '0, '0, '0},
			'{srtf_pkg::CMD_ARRIVE, 8'h11, 16'd0,  1'b0, '0, '0, '0, '0, '0, '0, '0},
			'{srtf_pkg::CMD_ARRIVE, 8'h12, 16'd3,  1'b0, '0, '0, '0, '0, '0, '0, '0},
			'{srtf_pkg::CMD_ARRIVE, 8'h80, 16'd5,  1'b0, '0, '0, '0, '0, '0, '0, '0},
			'{srtf_pkg::CMD_ARRIVE, 8'h01, 16'd4,  1'b0, '0, '0, '0, '0, '0, '0, '0},
			'{srtf_pkg::CMD_ARRIVE, 8'h7F, 16'd6,  1'b0, '0, '0, '0, '0, '0, '0, '0},
			'{srtf_pkg::CMD_ARRIVE, 8'h20, 16'd8,  1'b0, '0, '0, '0, '0, '0, '0, '0},
			'{srtf_pkg::CMD_ARRIVE, 8'h21, 16'd9,  1'b0, '0, '0, '0, '0, '0, '0, '0},
			'{srtf_pkg::CMD_ARRIVE, 8'h22, 16'd10, 1'b0, '0, '0, '0, '0, '0, '0, '0},
			'{srtf_pkg::CMD_ARRIVE, 8'h23, 16'd11, 1'b0, '0, '0, '0, '0, '0, '0, '0},
			'{srtf_pkg::CMD_ARRIVE, 8'h24, 16'd12, 1'b0, '0, '0, '0, '0, '0, '0, '0},
			'{srtf_pkg::CMD_ARRIVE, 8'h25, 16'd13, 1'b0, '0, '0, '0, '0, '0, '0, '0},
			'{srtf_pkg::CMD_ARRIVE, 8'hFE, 16'd14, 1'b0, '0, '0, '0, '0, '0, '0, '0},
			// all sixteen slots taken
			'{srtf_pkg::CMD_ARRIVE, 8'h5A, 16'd1, 1'b1, srtf_pkg::STAT_FULL,
				8'h00, 1'b0, 24'd0, 24'd0, 24'd0, 24'd2},
			'{srtf_pkg::CMD_TICK, 8'h00, 16'd0,    1'b0, '0, '0, '0, '0, '0, '0, '0},
			'{srtf_pkg::CMD_TICK, 8'hFF, 16'hFFFF, 1'b0, '0, '0, '0, '0, '0, '0, '0},
			'{srtf_pkg::CMD_TICK, 8'h00, 16'd0,    1'b0, '0, '0, '0, '0, '0, '0, '0},
			'{srtf_pkg::CMD_TICK, 8'h00, 16'd0,    1'b0, '0, '0, '0, '0, '0, '0, '0}
		};
		for (int s = 0; s < SLOTS; s++)
			sch_valid[s] = 1'b0;
		sch_time = '0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gap_pct   = 20;
		stall_pct = 20;
		for (int i = 0; i < DIR_ROWS; i++) begin
			offer_item(dir_rows[i].cmd, dir_rows[i].id, dir_rows[i].burst);
			predicted = schedule_step(dir_rows[i].cmd, dir_rows[i].id, dir_rows[i].burst);
			if (dir_rows[i].typed) begin
				typed_want.status     = srtf_pkg::status_t'(dir_rows[i].status);
				typed_want.run_id     = dir_rows[i].run_id;
				typed_want.finished   = dir_rows[i].finished;
				typed_want.turnaround = dir_rows[i].turnaround;
				typed_want.waiting    = dir_rows[i].waiting;
				typed_want.response   = dir_rows[i].response;
				typed_want.time_now   = dir_rows[i].time_now;
				note_expected(typed_want);
			end else begin
				note_expected(predicted);
			end
		end

		arrive_pct = 50;
		for (int i = 0; i < RAND_ITEMS; i++) begin
			// new traffic mix every hundred items: fill up, drain, or balanced
			if (i % 100 == 0) begin
				arrive_pct = $urandom_range(15, 90);
				case ($urandom_range(0, 3))
					0: gap_pct = 0;
					1: gap_pct = 10;
					2: gap_pct = 30;
					default: gap_pct = 60;
				endcase
				case ($urandom_range(0, 3))
					0: stall_pct = 0;
					1: stall_pct = 10;
					2: stall_pct = 30;
					default: stall_pct = 60;
				endcase
			end
			if (i >= RAND_ITEMS - QUIET_ITEMS)
				idle_off = 1'b1;
			// long jobs never finish in this run, so keep only a few resident
			long_jobs = 0;
			for (int s = 0; s < SLOTS; s++)
				if (sch_valid[s] && sch_left[s] > 16'd1000)
					long_jobs++;
			rnd_cmd = ($urandom_range(0, 99) < arrive_pct) ?
				srtf_pkg::CMD_ARRIVE : srtf_pkg::CMD_TICK;
			rnd_id  = 8'($urandom_range(0, 255));
			if (rnd_cmd == srtf_pkg::CMD_TICK)
				rnd_burst = 16'($urandom);
			else if (long_jobs < 3 && $urandom_range(0, 39) == 0)
				rnd_burst = 16'($urandom);
			else if ($urandom_range(0, 19) == 0)
				rnd_burst = 16'd0;
			else
				rnd_burst = 16'($urandom_range(1, 12));
			offer_item(rnd_cmd, rnd_id, rnd_burst);
			note_expected(schedule_step(rnd_cmd, rnd_id, rnd_burst));
		end
		s_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("sent %0d items: %0d accepted, %0d table full, %0d ran, %0d idle ticks",
			items_sent, status_count[srtf_pkg::STAT_ACCEPT],
			status_count[srtf_pkg::STAT_FULL], status_count[srtf_pkg::STAT_RAN],
			status_count[srtf_pkg::STAT_IDLE]);
		$display("%0d processes completed, %0d results checked, %0d mismatches",
			completions, results_seen, errors);
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
